@@ rtl/feedback_echo_delay_top_assert.svh @@
// Assertion helpers shared by the echo delay RTL.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef FEEDBACK_ECHO_DELAY_TOP_ASSERT_SVH
`define FEEDBACK_ECHO_DELAY_TOP_ASSERT_SVH

// Condition must never hold.
`define FED_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define FED_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the following cycle.
`define FED_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/fed_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fed_pkg
// Shared types, register codes and constants of the feedback echo delay.
// ----------------------------------------------------------------------------
package fed_pkg;

  localparam int CHANNELS_DEF    = 2;
  localparam int MAX_DELAY_DEF   = 4096;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int CH_W       = 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DLEN_W     = 13;
  localparam int GAIN_W     = 16;
  localparam int GAIN_Q_W   = 17;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WET_MIX       = 2'd2;

  localparam logic [DLEN_W-1:0]   DLEN_RESET = 13'd4096;
  localparam logic [GAIN_W-1:0]   GAIN_RESET = 16'd16384;
  localparam logic [GAIN_Q_W-1:0] UNITY_Q15  = 17'd32768;

  // Output queue depth; also the number of beats allowed in flight.
  localparam int OQ_DEPTH = 4;

  typedef struct packed {
    logic vld;  // beat accepted this cycle
    logic ok;   // channel is in range, state is touched
  } req_t;

  typedef struct packed {
    logic [GAIN_Q_W-1:0] fb;
    logic [GAIN_Q_W-1:0] wet;
    logic [GAIN_Q_W-1:0] dry;
  } gain_t;

  function automatic logic [GAIN_Q_W-1:0] clamp_gain(input logic [GAIN_W-1:0] g);
    return ({1'b0, g} > UNITY_Q15) ? UNITY_Q15 : {1'b0, g};
  endfunction

endpackage

@@ rtl/fed_ring_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fed_ring_mem
// Delay line storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fed_ring_mem #(
  parameter int AW = 13,
  parameter int DW = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read-first: a same-cycle write is not visible here.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/fed_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fed_datapath
// Two-stage echo arithmetic: feedback write-back with forwarding, then mix.
// ----------------------------------------------------------------------------
module fed_datapath #(
  parameter int SAMPLE_BITS = fed_pkg::SAMPLE_BITS_DEF,
  parameter int AW          = 13
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fed_pkg::req_t                 req_i,
  input  logic [AW-1:0]                 addr_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  fed_pkg::gain_t                gain_i,
  input  logic signed [SAMPLE_BITS-1:0] rdata_i,
  output logic                          wr_en_o,
  output logic [AW-1:0]                 wr_addr_o,
  output logic signed [SAMPLE_BITS-1:0] wr_data_o,
  output logic                          push_o,
  output logic signed [SAMPLE_BITS-1:0] push_data_o
);

  localparam int SB  = SAMPLE_BITS;
  localparam int PRW = SB + fed_pkg::GAIN_Q_W + 1;
  localparam int SHW = PRW - 15;
  localparam int EW  = SB + 4;
  localparam logic signed [EW-1:0] MAXV = {5'b00000, {(SB-1){1'b1}}};
  localparam logic signed [EW-1:0] MINV = {5'b11111, {(SB-1){1'b0}}};

  function automatic logic signed [SB-1:0] sat_fn(input logic signed [EW-1:0] v);
    logic signed [SB-1:0] r;
    if (v > MAXV) begin
      r = MAXV[SB-1:0];
    end else if (v < MINV) begin
      r = MINV[SB-1:0];
    end else begin
      r = v[SB-1:0];
    end
    return r;
  endfunction

  // Stage 1 registers
  logic                 s1_vld_q, s1_ok_q;
  logic [AW-1:0]        s1_addr_q;
  logic signed [SB-1:0] s1_x_q;

  // Forwarding of the last write-back
  logic                 fwd_vld_q;
  logic [AW-1:0]        fwd_addr_q;
  logic signed [SB-1:0] fwd_data_q;

  // Stage 2 registers
  logic                  s2_vld_q, s2_ok_q;
  logic signed [SB-1:0]  s2_x_q;
  logic signed [PRW-1:0] s2_dry_q, s2_wet_q;

  logic                  fwd_hit;
  logic signed [SB-1:0]  delayed;
  logic signed [PRW-1:0] fb_prod, wet_prod, dry_prod;
  logic signed [SHW-1:0] fb_sh, wet_sh, dry_sh;
  logic signed [EW-1:0]  fb_sum, y_sum;
  logic signed [SB-1:0]  stored;

  always_comb begin
    fwd_hit  = fwd_vld_q && (fwd_addr_q == s1_addr_q);
    delayed  = fwd_hit ? fwd_data_q : rdata_i;
    fb_prod  = PRW'(delayed) * PRW'($signed({1'b0, gain_i.fb}));
    wet_prod = PRW'(delayed) * PRW'($signed({1'b0, gain_i.wet}));
    dry_prod = PRW'(s1_x_q) * PRW'($signed({1'b0, gain_i.dry}));
    fb_sh    = $signed(fb_prod[PRW-1:15]);
    fb_sum   = EW'(s1_x_q) + EW'(fb_sh);
    stored   = sat_fn(fb_sum);
  end

  assign wr_en_o   = s1_vld_q & s1_ok_q;
  assign wr_addr_o = s1_addr_q;
  assign wr_data_o = stored;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      fwd_vld_q <= 1'b0;
      s2_vld_q  <= 1'b0;
    end else begin
      s1_vld_q  <= req_i.vld;
      fwd_vld_q <= wr_en_o;
      s2_vld_q  <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_ok_q    <= req_i.ok;
    s1_addr_q  <= addr_i;
    s1_x_q     <= sample_i;
    fwd_addr_q <= s1_addr_q;
    fwd_data_q <= stored;
    s2_ok_q    <= s1_ok_q;
    s2_x_q     <= s1_x_q;
    s2_dry_q   <= dry_prod;
    s2_wet_q   <= wet_prod;
  end

  always_comb begin
    dry_sh = $signed(s2_dry_q[PRW-1:15]);
    wet_sh = $signed(s2_wet_q[PRW-1:15]);
    y_sum  = EW'(dry_sh) + EW'(wet_sh);
  end

  // Out-of-range channels pass the sample through untouched.
  assign push_o      = s2_vld_q;
  assign push_data_o = s2_ok_q ? sat_fn(y_sum) : s2_x_q;

endmodule

@@ rtl/fed_out_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fed_out_queue
// Small result queue that decouples the pipeline from the output handshake.
// ----------------------------------------------------------------------------
module fed_out_queue #(
  parameter int W     = 16,
  parameter int DEPTH = fed_pkg::OQ_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         valid_o,
  input  logic         ready_i,
  output logic [W-1:0] data_o
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [W-1:0]    slot_q [DEPTH];
  logic [PTRW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            pop;

  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign pop     = valid_o & ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CNTW'(push_i) - CNTW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/feedback_echo_delay_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feedback_echo_delay_top
// Multichannel feedback echo built around one delay line memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry a channel number and a signed sample over a
//   valid/ready channel; each accepted beat yields exactly one mixed sample
//   on the output valid/ready channel, in order.
//   Output valid rises once a beat has passed the memory read, then feedback
//   and products, then the mix into the result queue. While input ready is high
//   the block takes one beat per cycle: a single memory read-modify-write per
//   beat, with the last write-back forwarded to the following read.
//   Up to 4 beats may be in flight; results wait in a 4-entry queue, so a
//   stalled receiver drops input ready once 4 beats are outstanding.
//   After reset and after every delay length register write, the delay memory is
//   swept to zero one entry per cycle over all 2**(CW+PW) entries (8192 with the
//   defaults); input ready stays low during the sweep. Gains and delay length must
//   be written through the config port only while the block is idle; the block
//   does not enforce this. Channels at or above CHANNELS pass through unchanged.
// ----------------------------------------------------------------------------
`include "feedback_echo_delay_top_assert.svh"

module feedback_echo_delay_top #(
  parameter int CHANNELS    = fed_pkg::CHANNELS_DEF,
  parameter int MAX_DELAY   = fed_pkg::MAX_DELAY_DEF,
  parameter int SAMPLE_BITS = fed_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fed_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [fed_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [fed_pkg::CH_W-1:0]         channel_i,
  input  logic signed [SAMPLE_BITS-1:0]    sample_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]    mixed_sample_o
);

  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW    = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int AW    = CW + PW;
  localparam int LW    = (fed_pkg::DLEN_W > PW + 1) ? fed_pkg::DLEN_W : PW + 1;
  localparam int CNTW  = $clog2(fed_pkg::OQ_DEPTH + 1);

  // Configuration registers
  logic [fed_pkg::DLEN_W-1:0] dlen_q;
  logic [fed_pkg::GAIN_W-1:0] fb_q, mix_q;
  logic                       dlen_wr;

  // Clearing sweep
  logic          clearing_q;
  logic [AW-1:0] clr_addr_q;

  // Per-channel write positions and beat credits
  logic [PW-1:0]   pos_q [CHANNELS];
  logic [CNTW-1:0] cnt_q;

  logic           in_accept, out_pop, ch_ok;
  logic [CW-1:0]  ch_idx;
  logic [PW-1:0]  pos_cur, pos_next, last_pos;
  logic [LW-1:0]  dlen_ext, ring_len;
  logic [AW-1:0]  rd_addr;

  fed_pkg::req_t  req;
  fed_pkg::gain_t gain;

  logic                          dp_we;
  logic [AW-1:0]                 dp_waddr;
  logic signed [SAMPLE_BITS-1:0] dp_wdata, mem_rdata, push_data;
  logic                          push;
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [SAMPLE_BITS-1:0]        mem_wdata, mem_rdata_raw, q_data;

  assign dlen_wr   = cfg_we_i && (cfg_idx_i == fed_pkg::REG_DELAY_LENGTH);
  assign in_ready_o = !clearing_q && (cnt_q < CNTW'(fed_pkg::OQ_DEPTH));
  assign in_accept = in_valid_i && in_ready_o;
  assign out_pop   = out_valid_o && out_ready_i;

  // Ring length: zero reads as one, long values clip to MAX_DELAY.
  always_comb begin
    dlen_ext = LW'(dlen_q);
    if (dlen_ext == '0) begin
      ring_len = LW'(1);
    end else if (dlen_ext > LW'(MAX_DELAY)) begin
      ring_len = LW'(MAX_DELAY);
    end else begin
      ring_len = dlen_ext;
    end
    last_pos = PW'(ring_len - LW'(1));
  end

  always_comb begin
    ch_ok    = (32'(channel_i) < 32'(CHANNELS));
    ch_idx   = ch_ok ? CW'(channel_i) : '0;
    pos_cur  = pos_q[ch_idx];
    pos_next = (pos_cur == last_pos) ? '0 : pos_cur + 1'b1;
    rd_addr  = {ch_idx, pos_cur};
    req.vld  = in_accept;
    req.ok   = ch_ok;
    gain.fb  = fed_pkg::clamp_gain(fb_q);
    gain.wet = fed_pkg::clamp_gain(mix_q);
    gain.dry = fed_pkg::UNITY_Q15 - fed_pkg::clamp_gain(mix_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dlen_q <= fed_pkg::DLEN_RESET;
      fb_q   <= fed_pkg::GAIN_RESET;
      mix_q  <= fed_pkg::GAIN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fed_pkg::REG_DELAY_LENGTH:  dlen_q <= cfg_wdata_i[fed_pkg::DLEN_W-1:0];
        fed_pkg::REG_FEEDBACK_GAIN: fb_q   <= cfg_wdata_i[fed_pkg::GAIN_W-1:0];
        fed_pkg::REG_WET_MIX:       mix_q  <= cfg_wdata_i[fed_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Sweep the whole memory to zero; restart on a delay length write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (dlen_wr) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (&clr_addr_q) begin
        clearing_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        pos_q[c] <= '0;
      end
    end else if (dlen_wr) begin
      for (int c = 0; c < CHANNELS; c++) begin
        pos_q[c] <= '0;
      end
    end else if (in_accept && ch_ok) begin
      pos_q[ch_idx] <= pos_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + CNTW'(in_accept) - CNTW'(out_pop);
    end
  end

  assign mem_we    = clearing_q | dp_we;
  assign mem_waddr = clearing_q ? clr_addr_q : dp_waddr;
  assign mem_wdata = clearing_q ? '0 : dp_wdata;
  assign mem_rdata = mem_rdata_raw;

  fed_ring_mem #(
    .AW (AW),
    .DW (SAMPLE_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (in_accept && ch_ok),
    .raddr_i (rd_addr),
    .rdata_o (mem_rdata_raw)
  );

  fed_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .AW          (AW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .addr_i      (rd_addr),
    .sample_i    (sample_i),
    .gain_i      (gain),
    .rdata_i     (mem_rdata),
    .wr_en_o     (dp_we),
    .wr_addr_o   (dp_waddr),
    .wr_data_o   (dp_wdata),
    .push_o      (push),
    .push_data_o (push_data)
  );

  fed_out_queue #(
    .W     (SAMPLE_BITS),
    .DEPTH (fed_pkg::OQ_DEPTH)
  ) u_oq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (q_data)
  );

  assign mixed_sample_o = q_data;

  `FED_ASSERT_NEVER(a_credit_bound, cnt_q > CNTW'(fed_pkg::OQ_DEPTH), "beat credits overrun")
  `FED_ASSERT_IMPL(a_out_has_credit, out_valid_o, cnt_q != '0, "result without a beat in flight")
  `FED_ASSERT_NEVER(a_no_write_in_sweep, clearing_q && dp_we, "write-back during clearing sweep")
  `FED_ASSERT_IMPL(a_pos_in_ring, in_accept && ch_ok, pos_cur <= last_pos, "position past ring end")
  `FED_ASSERT_NEXT(a_dlen_restarts_sweep, dlen_wr, clearing_q && (clr_addr_q == '0), "sweep not restarted")

endmodule

@@ tb/feedback_echo_delay_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feedback_echo_delay_top_tb
// Self-checking bench for the multichannel feedback echo. Sample beats go in
// over valid/ready with random gaps. Mixed samples are taken with random
// receiver stalls. Results are checked in order: directed beats against their
// table values, all others against a local echo line predictor with its own
// ring store, write positions and gains. A directed table covers the sample
// extremes, gain saturation, the length limits, store clearing and ignored
// register indexes. Random phases follow, each with its own register setting.
// ----------------------------------------------------------------------------
module feedback_echo_delay_top_tb;
  import fed_pkg::*;

  localparam int LINE_DEPTH  = MAX_DELAY_DEF;
  localparam int PIPE_LAT    = 3;
  localparam int PHASES      = 10;
  localparam int PHASE_BEATS = 75;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
  localparam logic signed [15:0] S_MAX = 16'sh7fff;
  localparam logic signed [15:0] S_MIN = 16'sh8000;

  typedef enum logic {ROW_CFG, ROW_BEAT} row_kind_e;

  // Config rows use idx/val as register/data; beat rows use ch/val as the payload.
  typedef struct packed {
    row_kind_e               kind;
    logic [CFG_IDX_W-1:0]    idx;
    logic signed [15:0]      val;
    logic [CH_W-1:0]         ch;
    logic                    known;
    logic signed [15:0]      want;
  } row_t;

  localparam row_t DIR_ROWS [31] = '{
    // reset gains: half dry, half wet, store empty
    '{ROW_BEAT, REG_DELAY_LENGTH, S_MAX, 1'b0, 1'b1, 16'sd16383},
    '{ROW_BEAT, REG_DELAY_LENGTH, S_MIN, 1'b0, 1'b1, -16'sd16384},
    '{ROW_BEAT, REG_DELAY_LENGTH, 16'sd0, 1'b1, 1'b1, 16'sd0},
    // zero length acts as a one-sample ring; oversized gains clamp to unity
    '{ROW_CFG, REG_DELAY_LENGTH, 16'sd0, 1'b0, 1'b0, 16'sd0},
    '{ROW_CFG, REG_FEEDBACK_GAIN, 16'shffff, 1'b0, 1'b0, 16'sd0},
    '{ROW_CFG, REG_WET_MIX, 16'shffff, 1'b0, 1'b0, 16'sd0},
    '{ROW_BEAT, REG_DELAY_LENGTH, S_MAX, 1'b0, 1'b1, 16'sd0},
    '{ROW_BEAT, REG_DELAY_LENGTH, S_MAX, 1'b0, 1'b1, S_MAX},
    '{ROW_BEAT, REG_DELAY_LENGTH, S_MIN, 1'b0, 1'b1, S_MAX},
    '{ROW_BEAT, REG_DELAY_LENGTH, S_MIN, 1'b1, 1'b1, 16'sd0},
    '{ROW_BEAT, REG_DELAY_LENGTH, S_MIN, 1'b1, 1'b1, S_MIN},
    // fully dry, exact unity feedback, length beyond the line depth
    '{ROW_CFG, REG_WET_MIX, 16'sd0, 1'b0, 1'b0, 16'sd0},
    '{ROW_CFG, REG_FEEDBACK_GAIN, 16'sh8000, 1'b0, 1'b0, 16'sd0},
    '{ROW_CFG, REG_DELAY_LENGTH, 16'sd8191, 1'b0, 1'b0, 16'sd0},
    '{ROW_BEAT, REG_DELAY_LENGTH, S_MIN, 1'b0, 1'b1, S_MIN},
    '{ROW_BEAT, REG_DELAY_LENGTH, 16'sd12345, 1'b1, 1'b1, 16'sd12345},
    // two-sample ring, fully wet, no feedback
    '{ROW_CFG, REG_DELAY_LENGTH, 16'sd2, 1'b0, 1'b0, 16'sd0},
    '{ROW_CFG, REG_FEEDBACK_GAIN, 16'sd0, 1'b0, 1'b0, 16'sd0},
    '{ROW_CFG, REG_WET_MIX, 16'sh8000, 1'b0, 1'b0, 16'sd0},
    '{ROW_BEAT, REG_DELAY_LENGTH, 16'sd100, 1'b0, 1'b1, 16'sd0},
    '{ROW_BEAT, REG_DELAY_LENGTH, 16'sd200, 1'b0, 1'b1, 16'sd0},
    '{ROW_BEAT, REG_DELAY_LENGTH, 16'sd300, 1'b0, 1'b1, 16'sd100},
    // same length again must still wipe the line
    '{ROW_CFG, REG_DELAY_LENGTH, 16'sd2, 1'b0, 1'b0, 16'sd0},
    '{ROW_BEAT, REG_DELAY_LENGTH, 16'sd400, 1'b0, 1'b1, 16'sd0},
    '{ROW_BEAT, REG_DELAY_LENGTH, 16'sd500, 1'b1, 1'b1, 16'sd0},
    // unmapped index changes nothing
    '{ROW_CFG, REG_UNMAPPED, 16'shffff, 1'b0, 1'b0, 16'sd0},
    '{ROW_BEAT, REG_DELAY_LENGTH, 16'sd600, 1'b0, 1'b1, 16'sd0},
    '{ROW_BEAT, REG_DELAY_LENGTH, 16'sd700, 1'b0, 1'b1, 16'sd400},
    // upper data bits beyond the length field drop out: ring of 3
    '{ROW_CFG, REG_DELAY_LENGTH, 16'she003, 1'b0, 1'b0, 16'sd0},
    '{ROW_CFG, REG_FEEDBACK_GAIN, 16'sd24576, 1'b0, 1'b0, 16'sd0},
    '{ROW_CFG, REG_WET_MIX, 16'sd8192, 1'b0, 1'b0, 16'sd0}
  };

  localparam int TAIL_BEATS = 6;
  localparam logic signed [15:0] TAIL_SMP [TAIL_BEATS] =
    '{S_MAX, 16'shffff, -16'sd12345, 16'sd1, S_MIN, S_MAX};
  localparam logic [CH_W-1:0] TAIL_CH [TAIL_BEATS] =
    '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i   = REG_DELAY_LENGTH;
  logic [CFG_DATA_W-1:0]   cfg_wdata_i = '0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_ready_o;
  logic [CH_W-1:0]         channel_i   = '0;
  logic signed [15:0]      sample_i    = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [15:0]      mixed_sample_o;

  // Predictor state
  logic signed [15:0] echo_line [CHANNELS_DEF][LINE_DEPTH];
  int unsigned        line_pos [CHANNELS_DEF];
  logic [DLEN_W-1:0]  cur_len;
  logic [GAIN_W-1:0]  cur_fb;
  logic [GAIN_W-1:0]  cur_wet;

  logic signed [15:0] mix_q [$];
  int                 n_bad       = 0;
  bit                 sink_steady = 1'b0;

  feedback_echo_delay_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .channel_i     (channel_i),
    .sample_i      (sample_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .mixed_sample_o(mixed_sample_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint unsigned unity_clamp(logic [GAIN_W-1:0] g);
    return (g > 16'd32768) ? 32768 : longint'(g);
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return S_MAX;
    if (v < -32768) return S_MIN;
    return v[15:0];
  endfunction

  function automatic void wipe_line();
    foreach (echo_line[c, p]) echo_line[c][p] = '0;
    foreach (line_pos[c]) line_pos[c] = 0;
  endfunction

  // One beat through the echo line: read-modify-write the ring, return the mix.
  function automatic logic signed [15:0] next_mix(logic [CH_W-1:0] ch,
                                                  logic signed [15:0] smp);
    int unsigned len;
    int unsigned pos;
    longint      x;
    longint      dly;
    longint      fb;
    longint      wet;
    len = (cur_len == 0) ? 1 : ((cur_len > LINE_DEPTH) ? LINE_DEPTH : cur_len);
    pos = line_pos[ch];
    if (pos >= len) pos = 0;
    x   = smp;
    dly = echo_line[ch][pos];
    fb  = unity_clamp(cur_fb);
    wet = unity_clamp(cur_wet);
    echo_line[ch][pos] = clip16(x + ((dly * fb) >>> 15));
    pos++;
    if (pos >= len) pos = 0;
    line_pos[ch] = pos;
    return clip16(((x * (32768 - wet)) >>> 15) + ((dly * wet) >>> 15));
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 4))
      0:       return 16'd0;
      1:       return 16'd32768;
      2:       return 16'hffff;
      3:       return 16'($urandom_range(0, 32768));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_DELAY_LENGTH: begin
        cur_len = data[DLEN_W-1:0];
        wipe_line();
      end
      REG_FEEDBACK_GAIN: cur_fb = data;
      REG_WET_MIX:       cur_wet = data;
      default: ;
    endcase
  endtask

  // Drop valid and wait until every pending mix has come back.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (mix_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 2) @(posedge clk_i);
  endtask

  task automatic send_beat(logic [CH_W-1:0] ch, logic signed [15:0] smp, int gap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    channel_i  <= ch;
    sample_i   <= smp;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Receiver: draw a stall per beat, then take the next result and check it.
  initial begin
    int                 hold;
    logic signed [15:0] want;
    @(posedge rst_ni);
    forever begin
      hold = sink_steady ? 0 : $urandom_range(0, 17);
      if (hold != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      if (mix_q.size() == 0) begin
        $display("%0t: unexpected mixed_sample %0d", $time, mixed_sample_o);
        n_bad++;
      end else begin
        want = mix_q.pop_front();
        if (mixed_sample_o !== want) begin
          $display("%0t: mixed_sample expected %0d, actual %0d",
                   $time, want, mixed_sample_o);
          n_bad++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("feedback_echo_delay_top_tb: done, errors");
    $finish;
  end

  initial begin
    logic signed [15:0] y;
    logic signed [15:0] smp;
    logic [CH_W-1:0]    ch;
    bit                 src_steady;
    int                 pause_at;
    logic [15:0]        len_val;

    cur_len = DLEN_RESET;
    cur_fb  = GAIN_RESET;
    cur_wet = GAIN_RESET;
    wipe_line();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIR_ROWS[r]) begin
      if (DIR_ROWS[r].kind == ROW_CFG) begin
        settle();
        write_reg(DIR_ROWS[r].idx, DIR_ROWS[r].val);
      end else begin
        send_beat(DIR_ROWS[r].ch, DIR_ROWS[r].val, $urandom_range(0, 17));
        y = next_mix(DIR_ROWS[r].ch, DIR_ROWS[r].val);
        mix_q.push_back(DIR_ROWS[r].known ? DIR_ROWS[r].want : y);
      end
    end
    // short ring wraps here; predictor only
    for (int i = 0; i < TAIL_BEATS; i++) begin
      send_beat(TAIL_CH[i], TAIL_SMP[i], $urandom_range(0, 17));
      mix_q.push_back(next_mix(TAIL_CH[i], TAIL_SMP[i]));
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case ($urandom_range(0, 9))
        0:       len_val = 16'd0;
        1:       len_val = 16'd1;
        2:       len_val = 16'd4096;
        3:       len_val = 16'($urandom_range(0, 65535));
        4:       len_val = 16'($urandom_range(4097, 8191));
        default: len_val = 16'($urandom_range(1, 24));
      endcase
      write_reg(REG_DELAY_LENGTH, len_val);
      write_reg(REG_FEEDBACK_GAIN, pick_gain());
      write_reg(REG_WET_MIX, pick_gain());
      src_steady  = (ph % 3 == 1);
      sink_steady = (ph % 4 == 2);
      pause_at    = $urandom_range(10, 60);
      for (int i = 0; i < PHASE_BEATS; i++) begin
        if (i == pause_at) settle();
        ch = CH_W'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
          0:       smp = S_MAX;
          1:       smp = S_MIN;
          2:       smp = 16'($signed($urandom_range(0, 64)) - 32);
          default: smp = 16'($urandom_range(0, 65535));
        endcase
        send_beat(ch, smp, src_steady ? 0 : $urandom_range(0, 17));
        mix_q.push_back(next_mix(ch, smp));
      end
    end

    settle();
    if (n_bad == 0) begin
      $display("feedback_echo_delay_top_tb: done, clean");
    end else begin
      $display("feedback_echo_delay_top_tb: done, errors");
    end
    $finish;
  end

endmodule
